### src/fra_pkg.sv
// ---------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the frame ring allocator.
// ---------------------------------------------------------------------------
package fra_pkg;

   localparam int FRAME_SLOTS = 4;
   localparam int SLOT_IDX_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int DATA_W      = 24;
   localparam int ALIGN_BITS  = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DATA_W-1:0] BUFFER_SIZE_RESET = 24'd65536;
   localparam logic              ADDR_BUFFER_SIZE  = 1'b0;

   typedef enum logic [1:0] {
      OP_ALLOC      = 2'd0,
      OP_END_FRAME  = 2'd1,
      OP_FREE_FRAME = 2'd2,
      OP_NOP        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_MISALIGNED = 2'd1,
      STATUS_NO_SPACE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_CALC   = 2'd1,
      S_COMMIT = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic commit;
   } cmd_type;

endpackage

### src/fra_ctrl.sv
// ---------------------------------------------------------------------------
// fra_ctrl
// Sequencer for the allocator: capture a word, evaluate wrap, then commit
// into the result register once that register is free.
// ---------------------------------------------------------------------------
module fra_ctrl
   import fra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.calc    = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result register occupied");

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CALC))
      else $error("accepted word not evaluated next cycle");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise result valid");

endmodule

### src/fra_datapath.sv
// ---------------------------------------------------------------------------
// fra_datapath
// Allocator state, frame slots, size register and result register.
// ---------------------------------------------------------------------------
module fra_datapath
   import fra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [1:0]            req_op,
   input  logic [DATA_W-1:0]     req_alloc_size,
   input  logic [1:0]            req_frame_slot,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic [DATA_W-1:0]     rsp_offset,
   output logic [1:0]            rsp_status,
   output logic [DATA_W-1:0]     rsp_available
);

   logic                  restart;

   logic [DATA_W-1:0]     buffer_size_ff, buffer_size_in;
   logic [DATA_W-1:0]     write_offset_ff, write_offset_in;
   logic [DATA_W-1:0]     frame_used_ff, frame_used_in;
   logic [DATA_W-1:0]     space_left_ff, space_left_in;
   logic [DATA_W-1:0]     slot_usage_ff [FRAME_SLOTS];
   logic [DATA_W-1:0]     slot_usage_in [FRAME_SLOTS];

   op_type                op_ff;
   logic [DATA_W-1:0]     size_ff;
   logic [SLOT_IDX_W-1:0] slot_idx_ff;
   logic                  slot_ok_ff;

   logic                  misalign_ff;
   logic [DATA_W-1:0]     wrap_off_ff, wrap_off_in;
   logic [DATA_W:0]       wrap_used_ff, wrap_used_in;

   logic [DATA_W-1:0]     offset_ff, offset_in;
   status_type            status_ff, status_in;
   logic [DATA_W-1:0]     available_ff;

   logic [DATA_W:0]       off_plus;
   logic                  wrap;
   logic [DATA_W-1:0]     slack;
   logic [DATA_W+1:0]     need;
   logic                  grant;
   logic [DATA_W:0]       free_sum;
   logic [DATA_W-1:0]     slot_read;

   assign restart = psel && penable && pwrite && (paddr[2] == ADDR_BUFFER_SIZE);
   assign buffer_size_in = restart ? pwdata[DATA_W-1:0] : buffer_size_ff;
   assign prdata = (paddr[2] == ADDR_BUFFER_SIZE)
                   ? CSR_DATA_W'(buffer_size_ff) : '0;

   // evaluate wrap against the end of the ring
   always_comb begin
      off_plus = {1'b0, write_offset_ff} + {1'b0, size_ff};
      wrap     = off_plus >= {1'b0, buffer_size_ff};
      slack    = (write_offset_ff < buffer_size_ff)
                 ? (buffer_size_ff - write_offset_ff) : '0;
      wrap_off_in  = wrap ? '0 : write_offset_ff;
      wrap_used_in = {1'b0, frame_used_ff} + (wrap ? {1'b0, slack} : '0);
   end

   assign slot_read = slot_usage_ff[slot_idx_ff];

   always_comb begin
      need     = {1'b0, wrap_used_ff} + {2'b00, size_ff};
      grant    = need < {2'b00, space_left_ff};
      free_sum = {1'b0, space_left_ff} + {1'b0, slot_read};

      write_offset_in = write_offset_ff;
      frame_used_in   = frame_used_ff;
      space_left_in   = space_left_ff;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         slot_usage_in[i] = slot_usage_ff[i];
      end
      offset_in = '0;
      status_in = STATUS_OK;

      case (op_ff)
         OP_ALLOC: begin
            if (misalign_ff) begin
               status_in = STATUS_MISALIGNED;
            end else if (!grant) begin
               status_in = STATUS_NO_SPACE;
            end else begin
               offset_in       = wrap_off_ff;
               frame_used_in   = need[DATA_W-1:0];
               write_offset_in = wrap_off_ff + size_ff;
            end
         end
         OP_END_FRAME: begin
            if (slot_ok_ff) begin
               slot_usage_in[slot_idx_ff] = frame_used_ff;
               space_left_in = (space_left_ff > frame_used_ff)
                               ? (space_left_ff - frame_used_ff) : '0;
               frame_used_in = '0;
            end
         end
         OP_FREE_FRAME: begin
            if (slot_ok_ff) begin
               space_left_in = (free_sum > {1'b0, buffer_size_ff})
                               ? buffer_size_ff : free_sum[DATA_W-1:0];
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff  <= BUFFER_SIZE_RESET;
         write_offset_ff <= '0;
         frame_used_ff   <= '0;
         space_left_ff   <= BUFFER_SIZE_RESET;
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            slot_usage_ff[i] <= '0;
         end
      end else if (restart) begin
         buffer_size_ff  <= buffer_size_in;
         write_offset_ff <= '0;
         frame_used_ff   <= '0;
         space_left_ff   <= buffer_size_in;
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            slot_usage_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         write_offset_ff <= write_offset_in;
         frame_used_ff   <= frame_used_in;
         space_left_ff   <= space_left_in;
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            slot_usage_ff[i] <= slot_usage_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= op_type'(req_op);
         size_ff     <= req_alloc_size;
         slot_idx_ff <= SLOT_IDX_W'(req_frame_slot);
         slot_ok_ff  <= (int'(req_frame_slot) < FRAME_SLOTS);
         misalign_ff <= (req_alloc_size[ALIGN_BITS-1:0] != '0);
      end
      if (cmd.calc) begin
         wrap_off_ff  <= wrap_off_in;
         wrap_used_ff <= wrap_used_in;
      end
      if (cmd.commit) begin
         offset_ff    <= offset_in;
         status_ff    <= status_in;
         available_ff <= space_left_in;
      end
   end

   assign rsp_offset    = offset_ff;
   assign rsp_status    = status_ff;
   assign rsp_available = available_ff;

   a_space_bound: assert property (@(posedge clock) disable iff (reset)
      space_left_ff <= buffer_size_ff)
      else $error("available space above buffer size");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (status_in != STATUS_OK)) |=> (offset_ff == '0))
      else $error("refused allocate returned nonzero offset");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (op_ff == OP_END_FRAME) && slot_ok_ff && !restart)
      |=> (frame_used_ff == '0))
      else $error("end frame left usage behind");

endmodule

### src/frame_ring_allocator_unit.sv
// ---------------------------------------------------------------------------
// frame_ring_allocator_unit
// Ring allocator over a configurable buffer, space returned per frame.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_op, req_alloc_size,
//                                                 req_frame_slot
//   rsp      out        rsp_valid / rsp_ready     rsp_offset, rsp_status,
//                                                 rsp_available
//   csr      in/out     psel / penable / pready   paddr, pwdata, prdata
//
// A word passes through three steps: capture, wrap evaluation, commit.
// One word in flight; the next is taken the cycle after commit.
// Commit waits while the result register still holds an untaken word.
// Reset or a write of buffer_size clears offset, frame usage and all slots.
// ---------------------------------------------------------------------------
module frame_ring_allocator_unit
   import fra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [DATA_W-1:0]     req_alloc_size,
   input  logic [1:0]            req_frame_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_offset,
   output logic [1:0]            rsp_status,
   output logic [DATA_W-1:0]     rsp_available,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type cmd;

   assign pready = 1'b1;

   fra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   fra_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_alloc_size (req_alloc_size),
      .req_frame_slot (req_frame_slot),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .rsp_offset     (rsp_offset),
      .rsp_status     (rsp_status),
      .rsp_available  (rsp_available)
   );

endmodule

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Checks the frame ring allocator against an in-bench prediction of offset,
// status and available space. Directed words cover size extremes, alignment
// errors, wrap and refusal, frame end and free with saturation, and the ring
// size extremes; random frames of allocations, end and free run over many
// ring sizes with bursty requests and a stalling result side.
// ---------------------------------------------------------------------------
module tb_top;
   import fra_pkg::*;

   localparam int RANDOM_WORDS = 1900;
   localparam logic [CSR_ADDR_W-1:0] RING_SIZE_ADDR =
      CSR_ADDR_W'(4 * int'(ADDR_BUFFER_SIZE));

   typedef struct {
      logic [DATA_W-1:0] offset;
      status_type        status;
      logic [DATA_W-1:0] available;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = OP_NOP;
   logic [DATA_W-1:0]     req_alloc_size = '0;
   logic [1:0]            req_frame_slot = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [DATA_W-1:0]     rsp_offset;
   logic [1:0]            rsp_status;
   logic [DATA_W-1:0]     rsp_available;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predicted allocator state
   logic [DATA_W-1:0] ring_size;
   logic [DATA_W-1:0] wr_ptr;
   logic [DATA_W-1:0] frame_bytes;
   logic [DATA_W-1:0] free_bytes;
   logic [DATA_W-1:0] slot_bytes [FRAME_SLOTS];

   grant_type pending_grants [$];

   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int config_writes = 0;
   int grants_ok = 0;
   int misaligned_cnt = 0;
   int no_space_cnt = 0;
   int frames_ended = 0;
   int frames_freed = 0;
   int burst_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_hold = 0;

   frame_ring_allocator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_alloc_size (req_alloc_size),
      .req_frame_slot (req_frame_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_offset     (rsp_offset),
      .rsp_status     (rsp_status),
      .rsp_available  (rsp_available),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void reset_ring(input logic [DATA_W-1:0] bytes);
      ring_size   = bytes;
      wr_ptr      = '0;
      frame_bytes = '0;
      free_bytes  = bytes;
      for (int i = 0; i < FRAME_SLOTS; i++) slot_bytes[i] = '0;
   endfunction

   function automatic grant_type apply_command(input op_type op,
                                               input logic [DATA_W-1:0] size,
                                               input logic [1:0] slot);
      grant_type   r;
      logic [31:0] off;
      logic [31:0] used;
      logic [31:0] need;
      logic [31:0] sum;
      r.offset = '0;
      r.status = STATUS_OK;
      case (op)
         OP_ALLOC: begin
            if (size[ALIGN_BITS-1:0] != '0) begin
               r.status = STATUS_MISALIGNED;
               misaligned_cnt++;
            end else begin
               off  = 32'(wr_ptr);
               used = 32'(frame_bytes);
               if (off + 32'(size) >= 32'(ring_size)) begin
                  if (off < 32'(ring_size)) used += 32'(ring_size) - off;
                  off = '0;
               end
               need = used + 32'(size);
               if (need >= 32'(free_bytes)) begin
                  r.status = STATUS_NO_SPACE;
                  no_space_cnt++;
               end else begin
                  r.offset    = off[DATA_W-1:0];
                  frame_bytes = need[DATA_W-1:0];
                  wr_ptr      = off[DATA_W-1:0] + size;
                  grants_ok++;
               end
            end
         end
         OP_END_FRAME: begin
            if (int'(slot) < FRAME_SLOTS) begin
               slot_bytes[slot] = frame_bytes;
               free_bytes = (free_bytes > frame_bytes) ? free_bytes - frame_bytes : '0;
               frame_bytes = '0;
               frames_ended++;
            end
         end
         OP_FREE_FRAME: begin
            if (int'(slot) < FRAME_SLOTS) begin
               sum = 32'(free_bytes) + 32'(slot_bytes[slot]);
               if (sum > 32'(ring_size)) sum = 32'(ring_size);
               free_bytes = sum[DATA_W-1:0];
               frames_freed++;
            end
         end
         default: ;
      endcase
      r.available = free_bytes;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_alloc_size();
      int unsigned       pick;
      logic [31:0]       lim;
      logic [DATA_W-1:0] s;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         s = DATA_W'($urandom);
         if (s[ALIGN_BITS-1:0] == '0) s[0] = 1'b1;
      end else if (pick < 10) begin
         s = '0;
      end else if (pick < 14) begin
         s = DATA_W'($urandom) & ~DATA_W'(15);
      end else begin
         lim = 32'(ring_size) >> $urandom_range(2, 6);
         if (lim < 32) lim = 32;
         s = DATA_W'($urandom_range(0, lim)) & ~DATA_W'(15);
      end
      return s;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_ring_size();
      case ($urandom_range(0, 9))
         0: return 32'd16;
         1: return 32'hFFFFFF;
         2: return 32'd65536;
         3: return 32'($urandom_range(17, 255));
         4: return 32'($urandom_range(256, 4096));
         5: return 32'($urandom_range(4096, 1 << 20));
         6: return $urandom & 32'hFFFFFF;
         7: return ($urandom_range(0, 2) == 0) ? 32'd0 : 32'd512;
         default: return 32'($urandom_range(1024, 65536)) & ~32'd15;
      endcase
   endfunction

   task automatic send_command(input op_type op, input logic [DATA_W-1:0] size,
                               input logic [1:0] slot);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_alloc_size <= size;
      req_frame_slot <= slot;
      do @(posedge clock); while (!req_ready);
      pending_grants.push_back(apply_command(op, size, slot));
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_ring_size(input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RING_SIZE_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      reset_ring(value[DATA_W-1:0]);
      config_writes++;
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[DATA_W-1:0] !== ring_size) begin
         $error("prdata: expected %0h, got %0h", ring_size, prdata[DATA_W-1:0]);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_frame(input int idx);
      int         n;
      logic [1:0] slot;
      n = $urandom_range(0, 6);
      repeat (n) send_command(OP_ALLOC, pick_alloc_size(), 2'($urandom));
      slot = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'(idx);
      send_command(OP_END_FRAME, DATA_W'($urandom), slot);
      if ($urandom_range(0, 7) != 0) begin
         slot = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'(idx + 2);
         send_command(OP_FREE_FRAME, DATA_W'($urandom), slot);
      end
   endtask

   task automatic test_alloc_basics();
      send_command(OP_ALLOC, 24'h000000, 2'd3);
      send_command(OP_ALLOC, 24'h000010, 2'd0);
      send_command(OP_ALLOC, 24'h00000F, 2'd1);
      send_command(OP_ALLOC, 24'hFFFFFF, 2'd2);
      send_command(OP_ALLOC, 24'hFFFFF0, 2'd3);
      send_command(OP_ALLOC, 24'h008000, 2'd0);
      send_command(OP_ALLOC, 24'h00FFE0, 2'd0);
   endtask

   task automatic test_frame_cycle();
      send_command(OP_END_FRAME,  24'h000000, 2'd0);
      send_command(OP_ALLOC,      24'h004000, 2'd0);
      send_command(OP_ALLOC,      24'h004000, 2'd0);
      send_command(OP_FREE_FRAME, 24'h000000, 2'd0);
      send_command(OP_FREE_FRAME, 24'hFFFFFF, 2'd0);
      send_command(OP_ALLOC,      24'h004000, 2'd0);
      send_command(OP_END_FRAME,  24'h000000, 2'd1);
      send_command(OP_END_FRAME,  24'h000000, 2'd2);
      send_command(OP_FREE_FRAME, 24'h000000, 2'd3);
      send_command(OP_NOP,        24'hAAAAA5, 2'd3);
      send_command(OP_FREE_FRAME, 24'h555550, 2'd1);
   endtask

   task automatic test_ring_size_extremes();
      drain();
      write_ring_size(32'd16);
      send_command(OP_ALLOC, 24'h000000, 2'd0);
      send_command(OP_ALLOC, 24'h000010, 2'd0);
      drain();
      write_ring_size(32'd0);
      send_command(OP_ALLOC, 24'h000000, 2'd0);
      drain();
      write_ring_size(32'hA5FF_FFFF);
      send_command(OP_ALLOC,      24'h7FFFF0, 2'd0);
      send_command(OP_ALLOC,      24'h7FFFF0, 2'd0);
      send_command(OP_END_FRAME,  24'h000000, 2'd3);
      send_command(OP_FREE_FRAME, 24'h000000, 2'd3);
   endtask

   task automatic test_random_traffic();
      int frame_idx;
      int phase_left;
      int stop_at;
      frame_idx  = 0;
      phase_left = 0;
      stop_at    = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         if (phase_left <= 0) begin
            drain();
            write_ring_size(pick_ring_size());
            phase_left = $urandom_range(80, 250);
         end
         if ($urandom_range(0, 4) != 0) begin
            run_frame(frame_idx);
            frame_idx++;
            phase_left -= 5;
         end else begin
            send_command(op_type'($urandom_range(0, 3)), DATA_W'($urandom),
                         2'($urandom));
            phase_left--;
         end
      end
   endtask

   // result side stall pattern
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= $urandom_range(0, 3);
         rx_mode_left <= $urandom_range(40, 300);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: begin
            if (rx_hold != 0) begin
               rx_hold   <= rx_hold - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 12);
            end
         end
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $error("result word with nothing expected: offset %0h status %0d",
                   rsp_offset, rsp_status);
            errors++;
         end else begin
            want = pending_grants.pop_front();
            words_checked++;
            if (rsp_offset !== want.offset) begin
               $error("offset: expected %0h, got %0h", want.offset, rsp_offset);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_available !== want.available) begin
               $error("available: expected %0h, got %0h", want.available,
                      rsp_available);
               errors++;
            end
         end
      end
   end

   initial begin
      reset_ring(BUFFER_SIZE_RESET);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_alloc_basics();
      test_frame_cycle();
      test_ring_size_extremes();
      test_random_traffic();
      drain();
      repeat (16) @(posedge clock);
      if (pending_grants.size() != 0) begin
         $error("%0d expected result words never arrived", pending_grants.size());
         errors++;
      end
      $display("summary: %0d words checked over %0d ring sizes; %0d frames ended, %0d freed",
               words_checked, config_writes, frames_ended, frames_freed);
      $display("summary: %0d grants, %0d misaligned, %0d out of space",
               grants_ok, misaligned_cnt, no_space_cnt);
      if (errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
